>>> rtl/rwfd_pkg.sv
// shared types and constants for the resolution weight pipeline
package rwfd_pkg;

    // mode register codes
    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_CONST  = 2'd1,
        MODE_PLANE  = 2'd2,
        MODE_SPHERE = 2'd3
    } mode_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_EXPLICIT = 3'd1,
        REG_HYBRID   = 3'd2,
        REG_CONST_W  = 3'd3,
        REG_CENTER_X = 3'd4,
        REG_CENTER_Y = 3'd5,
        REG_CENTER_Z = 3'd6,
        REG_SPARE    = 3'd7
    } reg_idx_t;

    // region codes
    typedef enum logic [1:0] {
        REGION_COARSE   = 2'd0,
        REGION_EXPLICIT = 2'd1,
        REGION_HYBRID   = 2'd2,
        REGION_UNUSED   = 2'd3
    } region_t;

    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam logic [30:0] Q30_ONE    = 31'd1073741824;
    localparam logic [30:0] Q30_HALF   = 31'd536870912;

    // odd sine polynomial, Q30
    localparam logic [32:0] C1  = 33'd3373259426;
    localparam logic [32:0] C3  = 33'd5548789346;
    localparam logic [32:0] C5  = 33'd2738217788;
    localparam logic [32:0] C7  = 33'd643455389;
    localparam logic [32:0] C9  = 33'd88203474;
    localparam logic [32:0] C11 = 33'd7913940;

    // per-stage tag: a weight already settled and bypassing the math
    typedef struct packed {
        logic        fix;
        logic [16:0] wfix;
    } tag_t;

endpackage

>>> rtl/resolution_weight_from_distance.sv
// resolution weight from particle distance, cos^2 hybrid transition, fully pipelined
//
//  channel  | dir | fields (lsb first)
//  ---------+-----+--------------------------------------------
//  s_*      | in  | tdata: pos_x[31:0] pos_y[63:32] pos_z[95:64]
//  m_*      | out | tdata: weight[16:0] region[18:17] zero pad
//  cfg_*    | in  | cfg_index selects register, cfg_data written
//
// one word accepted per cycle while the output word is not held by m_tready low
// most of the pipeline depth comes from the 32-step square root and 31-step divider chains
// reset clears only valid bits and configuration registers
// a stall on m_tready freezes every stage at once, nothing is dropped
module resolution_weight_from_distance (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // pos_x, pos_y, pos_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // weight, region, pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // stage map
    localparam int ST_SQRT0 = 4;
    localparam int ST_CMP   = 36;
    localparam int ST_DIV0  = 37;
    localparam int ST_AU    = 68;
    localparam int ST_V     = 69;
    localparam int ST_P9    = 70;
    localparam int ST_Q     = 75;
    localparam int NST      = 77;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [30:0] expl_reg;
    logic [30:0] hyb_reg;
    logic [16:0] cw_reg;
    logic [31:0] cx_reg;
    logic [31:0] cy_reg;
    logic [31:0] cz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rwfd_pkg::MODE_OFF;
            expl_reg <= '0;
            hyb_reg  <= 31'd65536;
            cw_reg   <= rwfd_pkg::WEIGHT_ONE;
            cx_reg   <= '0;
            cy_reg   <= '0;
            cz_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (rwfd_pkg::reg_idx_t'(cfg_index))
                rwfd_pkg::REG_MODE:     mode_reg <= cfg_data[1:0];
                rwfd_pkg::REG_EXPLICIT: expl_reg <= cfg_data[30:0];
                rwfd_pkg::REG_HYBRID:   hyb_reg  <= cfg_data[30:0];
                rwfd_pkg::REG_CONST_W:  cw_reg   <= cfg_data[16:0];
                rwfd_pkg::REG_CENTER_X: cx_reg   <= cfg_data;
                rwfd_pkg::REG_CENTER_Y: cy_reg   <= cfg_data;
                rwfd_pkg::REG_CENTER_Z: cz_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: the whole pipe moves unless the output word is held
    logic ce;
    logic [NST-1:0] vld_reg;
    rwfd_pkg::tag_t tag_reg [NST];
    rwfd_pkg::tag_t tag0_next;
    rwfd_pkg::tag_t tagc_next;

    assign ce       = !vld_reg[NST-1] || m_tready;
    assign s_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    // off and constant modes settle the weight at entry
    always_comb
    begin
        tag0_next.fix  = 1'b0;
        tag0_next.wfix = rwfd_pkg::WEIGHT_ONE;
        case (rwfd_pkg::mode_t'(mode_reg))
            rwfd_pkg::MODE_OFF:
            begin
                tag0_next.fix  = 1'b1;
                tag0_next.wfix = rwfd_pkg::WEIGHT_ONE;
            end
            rwfd_pkg::MODE_CONST:
            begin
                tag0_next.fix  = 1'b1;
                tag0_next.wfix = (cw_reg > rwfd_pkg::WEIGHT_ONE) ? rwfd_pkg::WEIGHT_ONE
                                                                  : cw_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (k == 0)
                    tag_reg[k] <= tag0_next;
                else if (k == ST_CMP)
                    tag_reg[k] <= tagc_next;
                else
                    tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // ---- offsets, squares, saturating sum ----
    logic [32:0] dx, dy, dz;
    logic [31:0] ax_reg, ay_reg, az_reg;
    logic [63:0] sx_reg, sy_reg, sz_reg;
    logic [64:0] sxy_reg;
    logic [63:0] sz2_reg;
    logic [63:0] sum_reg;
    logic [65:0] tot;
    logic        sph;

    assign dx  = {cx_reg[31], cx_reg} - {s_tdata[31], s_tdata[31:0]};
    assign dy  = {cy_reg[31], cy_reg} - {s_tdata[63], s_tdata[63:32]};
    assign dz  = {cz_reg[31], cz_reg} - {s_tdata[95], s_tdata[95:64]};
    assign sph = (mode_reg == rwfd_pkg::MODE_SPHERE);
    assign tot = {1'b0, sxy_reg} + {2'b0, sz2_reg};

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ax_reg  <= dx[32] ? 32'(-dx) : dx[31:0];
            ay_reg  <= dy[32] ? 32'(-dy) : dy[31:0];
            az_reg  <= dz[32] ? 32'(-dz) : dz[31:0];
            sx_reg  <= 64'(ax_reg) * 64'(ax_reg);
            sy_reg  <= 64'(ay_reg) * 64'(ay_reg);
            sz_reg  <= 64'(az_reg) * 64'(az_reg);
            sxy_reg <= {1'b0, sx_reg} + (sph ? {1'b0, sy_reg} : 65'd0);
            sz2_reg <= sph ? sz_reg : 64'd0;
            sum_reg <= (tot[65:64] != 2'b00) ? {64{1'b1}} : tot[63:0];
        end
    end

    // ---- square root, one result bit per stage ----
    logic [63:0] rx_reg   [32];
    logic [34:0] rrem_reg [32];
    logic [31:0] rq_reg   [32];

    for (genvar i = 0; i < 32; i++)
    begin : g_sqrt
        logic [63:0] x_in;
        logic [34:0] rem_in;
        logic [31:0] q_in;
        logic [34:0] sh;
        logic [34:0] trial;

        if (i == 0)
        begin : g_first
            assign x_in   = sum_reg;
            assign rem_in = '0;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign x_in   = rx_reg[i-1];
            assign rem_in = rrem_reg[i-1];
            assign q_in   = rq_reg[i-1];
        end

        assign sh    = {rem_in[32:0], x_in[63-2*i -: 2]};
        assign trial = {1'b0, q_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rx_reg[i] <= x_in;
                if (sh >= trial)
                begin
                    rrem_reg[i] <= sh - trial;
                    rq_reg[i]   <= {q_in[30:0], 1'b1};
                end
                else
                begin
                    rrem_reg[i] <= sh;
                    rq_reg[i]   <= {q_in[30:0], 1'b0};
                end
            end
        end
    end

    // ---- range check against explicit and hybrid widths ----
    logic [31:0] droot;
    logic [31:0] rw_sum;
    logic [30:0] n_reg;

    assign droot  = rq_reg[31];
    assign rw_sum = {1'b0, expl_reg} + {1'b0, hyb_reg};

    always_comb
    begin
        tagc_next = tag_reg[ST_CMP-1];
        if (!tagc_next.fix)
        begin
            if (droot > rw_sum)
            begin
                tagc_next.fix  = 1'b1;
                tagc_next.wfix = '0;
            end
            else if (droot < {1'b0, expl_reg})
            begin
                tagc_next.fix  = 1'b1;
                tagc_next.wfix = rwfd_pkg::WEIGHT_ONE;
            end
            else if (hyb_reg == '0)
            begin
                tagc_next.fix  = 1'b1;
                tagc_next.wfix = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            n_reg <= 31'(droot - {1'b0, expl_reg});
    end

    // ---- t = (d - r) * 2^30 / w, one quotient bit per stage ----
    logic [31:0] drem_reg [31];
    logic [30:0] dq_reg   [31];

    for (genvar j = 0; j < 31; j++)
    begin : g_div
        logic [31:0] rem_in;
        logic [30:0] q_in;
        logic [31:0] cand;

        if (j == 0)
        begin : g_first
            assign rem_in = {1'b0, n_reg};
            assign q_in   = '0;
            assign cand   = rem_in;
        end
        else
        begin : g_next
            assign rem_in = drem_reg[j-1];
            assign q_in   = dq_reg[j-1];
            assign cand   = {rem_in[30:0], 1'b0};
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (cand >= {1'b0, hyb_reg})
                begin
                    drem_reg[j] <= cand - {1'b0, hyb_reg};
                    dq_reg[j]   <= {q_in[29:0], 1'b1};
                end
                else
                begin
                    drem_reg[j] <= cand;
                    dq_reg[j]   <= {q_in[29:0], 1'b0};
                end
            end
        end
    end

    // ---- cos^2 via sine polynomial around t = 1/2 ----
    logic [30:0] t;
    logic [29:0] au_reg  [ST_AU:ST_Q-1];
    logic        neg_reg [ST_AU:ST_Q-1];
    logic [28:0] v_reg   [ST_V:ST_Q-2];
    logic [32:0] p_reg   [ST_P9:ST_Q-1];
    logic [59:0] vsq;
    logic [30:0] q_reg;
    logic [62:0] sprod;
    logic [32:0] s_raw;
    logic [30:0] s_cl;
    logic [31:0] q_sum;

    assign t   = dq_reg[30];
    assign vsq = 60'(au_reg[ST_AU]) * 60'(au_reg[ST_AU]);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            neg_reg[ST_AU] <= (t < rwfd_pkg::Q30_HALF);
            au_reg[ST_AU]  <= (t < rwfd_pkg::Q30_HALF) ? 30'(rwfd_pkg::Q30_HALF - t)
                                                        : 30'(t - rwfd_pkg::Q30_HALF);
            for (int k = ST_V; k < ST_Q; k++)
            begin
                au_reg[k]  <= au_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            v_reg[ST_V] <= vsq[58:30];
            for (int k = ST_P9; k < ST_Q-1; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // horner steps, coefficients high to low
    for (genvar h = 0; h < 5; h++)
    begin : g_horner
        localparam logic [32:0] CK = (h == 0) ? rwfd_pkg::C9 :
                                     (h == 1) ? rwfd_pkg::C7 :
                                     (h == 2) ? rwfd_pkg::C5 :
                                     (h == 3) ? rwfd_pkg::C3 : rwfd_pkg::C1;
        logic [32:0] p_in;
        logic [61:0] prod;

        if (h == 0)
        begin : g_first
            assign p_in = rwfd_pkg::C11;
        end
        else
        begin : g_next
            assign p_in = p_reg[ST_P9+h-1];
        end

        assign prod = 62'(v_reg[ST_P9+h-1]) * 62'(p_in);

        always_ff @(posedge clk)
        begin
            if (ce)
                p_reg[ST_P9+h] <= CK - prod[62-1:30];
        end
    end

    assign sprod = 63'(au_reg[ST_Q-1]) * 63'(p_reg[ST_Q-1]);
    assign s_raw = sprod[62:30];
    assign s_cl  = (s_raw > 33'(rwfd_pkg::Q30_ONE)) ? rwfd_pkg::Q30_ONE : s_raw[30:0];
    assign q_sum = neg_reg[ST_Q-1] ? ({1'b0, rwfd_pkg::Q30_ONE} + {1'b0, s_cl})
                                   : ({1'b0, rwfd_pkg::Q30_ONE} - {1'b0, s_cl});

    always_ff @(posedge clk)
    begin
        if (ce)
            q_reg <= q_sum[31:1];
    end

    // ---- final rounding, bypass select and region ----
    logic [31:0] w_round;
    logic [16:0] w_fin;
    logic [16:0] w_out_reg;
    logic [1:0]  reg_out_reg;

    assign w_round = {1'b0, q_reg} + 32'd8192;
    assign w_fin   = tag_reg[NST-2].fix ? tag_reg[NST-2].wfix : w_round[30:14];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            w_out_reg <= w_fin;
            if (w_fin == '0)
                reg_out_reg <= rwfd_pkg::REGION_COARSE;
            else if (w_fin == rwfd_pkg::WEIGHT_ONE)
                reg_out_reg <= rwfd_pkg::REGION_EXPLICIT;
            else
                reg_out_reg <= rwfd_pkg::REGION_HYBRID;
        end
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {5'b0, reg_out_reg, w_out_reg};

endmodule
